/* rtl/core/biquad_eq_cascade_assert.svh */
// Assertion macros for the equalizer core
`ifndef BIQUAD_EQ_CASCADE_ASSERT_SVH
`define BIQUAD_EQ_CASCADE_ASSERT_SVH

// same-cycle implication
`define BQE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BQE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bqe_pkg.sv */
package bqe_pkg;

    localparam int MAX_BANDS  = 8;
    localparam int CHANNELS   = 8;
    localparam int NUM_COEFS  = 5;
    localparam int BAND_W     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BCNT_W     = $clog2(MAX_BANDS + 1);
    localparam int HIST_DEPTH = CHANNELS * MAX_BANDS;
    localparam int HIST_AW    = CH_W + BAND_W;
    localparam int COEF_DEPTH = MAX_BANDS * NUM_COEFS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int SUM_SHIFT  = 28;

    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    typedef struct packed {
        logic signed [31:0] y2;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] x1;
    } hist_row_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic mul_sub;
        logic acc_en;
    } mac_ctl_t;

endpackage

/* rtl/core/bqe_coef_ram.sv */
module bqe_coef_ram import bqe_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               we,
    input  logic [COEF_AW-1:0] waddr,
    input  logic signed [31:0] wdata,
    input  logic [COEF_AW-1:0] raddr,
    output logic signed [31:0] rdata
);

    logic signed [31:0]  mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0] vld_reg;
    logic signed [31:0]  rd_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : 32'sd0;

endmodule

/* rtl/core/bqe_hist_ram.sv */
module bqe_hist_ram import bqe_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  logic               we,
    input  logic [HIST_AW-1:0] waddr,
    input  hist_row_t          wdata,
    input  logic               re,
    input  logic [HIST_AW-1:0] raddr,
    output hist_row_t          rdata
);

    hist_row_t             mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] vld_reg;
    hist_row_t             rd_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (clear) begin
                vld_reg <= '0;
            end else if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

/* rtl/core/bqe_mac.sv */
module bqe_mac import bqe_pkg::*; (
    input  logic               aclk,
    input  mac_ctl_t           ctl,
    input  logic signed [31:0] coef,
    input  logic signed [31:0] opnd,
    output logic signed [31:0] y
);

    logic signed [63:0] prod_reg;
    logic               sub_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] quarter;
    logic signed [63:0] rounded;
    logic signed [63:0] scaled;

    // truncate toward zero on both divides
    assign quarter = (prod_reg + (prod_reg[63] ? 64'sd3 : 64'sd0)) >>> 2;
    assign rounded = acc_reg
                   + (acc_reg[63] ? ((64'sd1 <<< SUM_SHIFT) - 64'sd1) : 64'sd0);
    assign scaled  = rounded >>> SUM_SHIFT;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= 64'(coef) * 64'(opnd);
            sub_reg  <= ctl.mul_sub;
        end
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= sub_reg ? acc_reg - quarter : acc_reg + quarter;
        end
    end

    always_comb begin
        if (scaled > 64'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (scaled < -64'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = scaled[31:0];
        end
    end

endmodule

/* rtl/core/biquad_eq_cascade.sv */
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | tuser: op; tdata: channel, sample, band_sel,
//         |     |                   |        coef_sel, coef_value
// m_      | out | m_tvalid/m_tready | tdata: filtered, out_channel
// cfg     | in  | cfg_we            | cfg_wdata: band_count
// A filter transfer runs, for each band, 5 coefficient reads on the single
// coefficient memory port, a multiply/accumulate drain and a history
// writeback; at zero bands it goes straight to its done state.
// Reset clears all coefficients and history through per-entry valid bits at once.
// A result waiting on m_tready holds the next filter transfer in its done state.
module biquad_eq_cascade import bqe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // channel, sample, band_sel, coef_sel, coef_value, pad
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // filtered, out_channel, pad
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FINAL,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [3:0]          band_count_reg;
    logic [BCNT_W-1:0]   bands_eff;
    logic [BAND_W-1:0]   band_reg;
    logic [2:0]          k_reg;
    logic [2:0]          k_d1_reg;
    logic                p1_reg;
    logic                p2_reg;
    logic [CH_W-1:0]     ch_reg;
    logic signed [31:0]  x_reg;
    logic                m_tvalid_reg;
    logic signed [31:0]  out_data_reg;
    logic [2:0]          out_ch_reg;

    logic [2:0]          in_channel;
    logic signed [31:0]  in_sample;
    logic [2:0]          in_band_sel;
    logic [2:0]          in_coef_sel;
    logic signed [31:0]  in_coef_value;
    logic                accept;

    logic                coef_we;
    logic [COEF_AW-1:0]  coef_waddr;
    logic [COEF_AW-1:0]  coef_raddr;
    logic signed [31:0]  coef_rdata;
    logic                hist_clear;
    logic                hist_we;
    logic                hist_re;
    logic [HIST_AW-1:0]  hist_addr;
    hist_row_t           hist_rdata;
    hist_row_t           hist_wdata;
    mac_ctl_t            mac_ctl;
    logic signed [31:0]  opnd;
    logic signed [31:0]  y;
    logic                last_band;
    logic                pipe_empty;

    assign in_channel    = s_tdata[2:0];
    assign in_sample     = s_tdata[34:3];
    assign in_band_sel   = s_tdata[37:35];
    assign in_coef_sel   = s_tdata[40:38];
    assign in_coef_value = s_tdata[72:41];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_ch_reg, out_data_reg};

    assign bands_eff = (int'(band_count_reg) > MAX_BANDS) ? BCNT_W'(MAX_BANDS)
                                                          : BCNT_W'(band_count_reg);
    assign last_band  = (BCNT_W'(band_reg) + BCNT_W'(1)) == bands_eff;
    assign pipe_empty = !p1_reg && !p2_reg;

    assign coef_we    = accept && (s_tuser == OP_COEF)
                        && (int'(in_band_sel) < MAX_BANDS) && (in_coef_sel <= SLOT_A2);
    assign coef_waddr = COEF_AW'(int'(in_band_sel) * NUM_COEFS + int'(in_coef_sel));
    assign coef_raddr = COEF_AW'(int'(band_reg) * NUM_COEFS + int'(k_reg));

    assign hist_clear = accept && (s_tuser == OP_CLEAR);
    assign hist_addr  = {ch_reg, band_reg};
    assign hist_re    = (state_reg == ST_ISSUE) && (k_reg == SLOT_B0);
    assign hist_we    = (state_reg == ST_FINAL) && pipe_empty;
    assign hist_wdata = '{y2: hist_rdata.y1, y1: y, x2: hist_rdata.x1, x1: x_reg};

    always_comb begin
        case (k_d1_reg)
            SLOT_B1: opnd = hist_rdata.x1;
            SLOT_B2: opnd = hist_rdata.x2;
            SLOT_A1: opnd = hist_rdata.y1;
            SLOT_A2: opnd = hist_rdata.y2;
            default: opnd = x_reg;
        endcase
    end

    assign mac_ctl = '{
        clr:     accept || hist_we,
        mul_en:  p1_reg,
        mul_sub: (k_d1_reg >= SLOT_A1),
        acc_en:  p2_reg
    };

    bqe_coef_ram u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (coef_we),
        .waddr   (coef_waddr),
        .wdata   (in_coef_value),
        .raddr   (coef_raddr),
        .rdata   (coef_rdata)
    );

    bqe_hist_ram u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (hist_clear),
        .we      (hist_we),
        .waddr   (hist_addr),
        .wdata   (hist_wdata),
        .re      (hist_re),
        .raddr   (hist_addr),
        .rdata   (hist_rdata)
    );

    bqe_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .coef (coef_rdata),
        .opnd (opnd),
        .y    (y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            band_count_reg <= '0;
            band_reg       <= '0;
            k_reg          <= SLOT_B0;
            k_d1_reg       <= SLOT_B0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            ch_reg         <= '0;
            x_reg          <= '0;
            m_tvalid_reg   <= 1'b0;
            out_data_reg   <= '0;
            out_ch_reg     <= '0;
        end else begin
            if (cfg_we) begin
                band_count_reg <= cfg_wdata;
            end
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            p1_reg   <= (state_reg == ST_ISSUE);
            k_d1_reg <= k_reg;
            p2_reg   <= p1_reg;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_tuser == OP_FILTER)
                        && (int'(in_channel) < CHANNELS)) begin
                        ch_reg   <= CH_W'(in_channel);
                        x_reg    <= in_sample;
                        band_reg <= '0;
                        k_reg    <= SLOT_B0;
                        state_reg <= (bands_eff == '0) ? ST_DONE : ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (k_reg == SLOT_A2) begin
                        k_reg     <= SLOT_B0;
                        state_reg <= ST_FINAL;
                    end else begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                ST_FINAL: begin
                    if (pipe_empty) begin
                        x_reg <= y;
                        if (last_band) begin
                            state_reg <= ST_DONE;
                        end else begin
                            band_reg  <= band_reg + BAND_W'(1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_data_reg <= x_reg;
                        out_ch_reg   <= 3'(ch_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`include "biquad_eq_cascade_assert.svh"

    `BQE_ASSERT_NOW(a_hist_wr_drained, hist_we, pipe_empty, "history write before drain")
    `BQE_ASSERT_NOW(a_issue_band_range, state_reg == ST_ISSUE, BCNT_W'(band_reg) < bands_eff, "band beyond count")
    `BQE_ASSERT_NEXT(a_out_from_done, !m_tvalid_reg && (state_reg != ST_DONE), !m_tvalid_reg, "result without completion")

endmodule
